// ===== src/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsdf_pkg;

  localparam int LENGTH_BITS_DEF = 64;

  // decoupling queue between header parser and message stage
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_ERR  = 3'd5
  } phase_t;

  // event codes; message types 1..5 share the same encoding
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_TEXT   = 3'd1;
  localparam logic [2:0] EV_BINARY = 3'd2;
  localparam logic [2:0] EV_CLOSE  = 3'd3;
  localparam logic [2:0] EV_PING   = 3'd4;
  localparam logic [2:0] EV_PONG   = 3'd5;
  localparam logic [2:0] EV_ERROR  = 3'd6;

  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // one classified word handed from parser to message stage
  typedef struct packed {
    logic       is_data;
    logic       is_end;
    logic       is_err;
    logic [2:0] mtype;
    logic [7:0] data;
  } op_t;

endpackage

// ===== src/wsdf_front.sv =====
// Frame header parser: phase tracking, length, mask key and unmasking.
// Depends on wsdf_pkg. Emits classified words (data, final end, error).
module wsdf_front import wsdf_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  input  logic       q_full,
  output logic       push,
  output op_t        op
);

  phase_t                 phase, phase_next;
  logic                   go;
  logic                   final_flag;
  logic                   masked;
  logic [2:0]             msg_type;
  logic [LENGTH_BITS-1:0] br;
  logic [LENGTH_BITS-1:0] br_shift;
  logic [LENGTH_BITS-1:0] br_dec;
  logic [3:0]             lbl;
  logic [3:0]             lbl_dec;
  logic [7:0]             mask_key [4];
  logic [1:0]             mpos;
  logic [6:0]             l7;
  logic                   is_ext;
  logic                   hdr_ok;
  logic [2:0]             hdr_type;
  logic                   frame_end;
  logic [7:0]             data_unmasked;

  assign in_ready = !q_full;
  assign go       = in_valid && in_ready;
  assign l7       = stream_byte[6:0];
  assign is_ext   = (l7 == LEN_EXT16) || (l7 == LEN_EXT64);
  assign br_shift = {br[LENGTH_BITS-9:0], stream_byte};
  assign br_dec   = br - LENGTH_BITS'(1);
  assign lbl_dec  = lbl - 4'd1;
  assign data_unmasked = masked ? (stream_byte ^ mask_key[mpos]) : stream_byte;

  // opcode / continuation check on the first header byte
  always_comb begin
    hdr_type = EV_NONE;
    hdr_ok   = (stream_byte[6:4] == 3'b000);
    case (stream_byte[3:0])
      OPC_CONT:   if (msg_type == EV_NONE) hdr_ok = 1'b0;
      OPC_TEXT:   hdr_type = EV_TEXT;
      OPC_BINARY: hdr_type = EV_BINARY;
      OPC_CLOSE:  hdr_type = EV_CLOSE;
      OPC_PING:   hdr_type = EV_PING;
      OPC_PONG:   hdr_type = EV_PONG;
      default:    hdr_ok = 1'b0;
    endcase
    if (stream_byte[3:0] != OPC_CONT && msg_type != EV_NONE) hdr_ok = 1'b0;
  end

  // this byte closes the current frame
  always_comb begin
    frame_end = 1'b0;
    case (phase)
      PH_LEN:  frame_end = !is_ext && !stream_byte[7] && (l7 == 7'd0);
      PH_EXT:  frame_end = (lbl_dec == 4'd0) && !masked && (br_shift == '0);
      PH_KEY:  frame_end = (mpos == 2'd3) && (br == '0);
      PH_DATA: frame_end = (br_dec == '0);
      default: frame_end = 1'b0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (go) begin
      case (phase)
        PH_HDR0: phase_next = hdr_ok ? PH_LEN : PH_ERR;
        PH_LEN: begin
          if (is_ext)              phase_next = PH_EXT;
          else if (stream_byte[7]) phase_next = PH_KEY;
          else if (l7 == 7'd0)     phase_next = PH_HDR0;
          else                     phase_next = PH_DATA;
        end
        PH_EXT: begin
          if (lbl_dec != 4'd0)     phase_next = PH_EXT;
          else if (masked)         phase_next = PH_KEY;
          else if (br_shift == '0) phase_next = PH_HDR0;
          else                     phase_next = PH_DATA;
        end
        PH_KEY: begin
          if (mpos != 2'd3)  phase_next = PH_KEY;
          else if (br == '0) phase_next = PH_HDR0;
          else               phase_next = PH_DATA;
        end
        PH_DATA: phase_next = (br_dec == '0) ? PH_HDR0 : PH_DATA;
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    op.is_err  = (phase == PH_HDR0) && !hdr_ok;
    op.is_data = (phase == PH_DATA);
    op.is_end  = frame_end && final_flag;
    op.mtype   = msg_type;
    op.data    = data_unmasked;
    push       = go && (op.is_err || op.is_data || op.is_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      final_flag <= 1'b0;
      masked     <= 1'b0;
      msg_type   <= EV_NONE;
      br         <= '0;
      lbl        <= 4'd0;
      mpos       <= 2'd0;
      for (int i = 0; i < 4; i++) mask_key[i] <= 8'd0;
    end else begin
      phase <= phase_next;
      if (go) begin
        case (phase)
          PH_HDR0: begin
            if (hdr_ok) begin
              if (hdr_type != EV_NONE) msg_type <= hdr_type;
              final_flag <= stream_byte[7];
            end
          end
          PH_LEN: begin
            masked <= stream_byte[7];
            if (is_ext) begin
              br  <= '0;
              lbl <= (l7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            end else begin
              br  <= LENGTH_BITS'(l7);
              lbl <= 4'd0;
              if (stream_byte[7]) mpos <= 2'd0;
            end
          end
          PH_EXT: begin
            br  <= br_shift;
            lbl <= lbl_dec;
            if (lbl_dec == 4'd0 && masked) mpos <= 2'd0;
          end
          PH_KEY: begin
            mask_key[mpos] <= stream_byte;
            mpos           <= mpos + 2'd1;
          end
          PH_DATA: begin
            br <= br_dec;
            if (masked) mpos <= mpos + 2'd1;
          end
          default: ;
        endcase
        if (frame_end && final_flag) msg_type <= EV_NONE;
      end
    end
  end

endmodule

// ===== src/wsdf_queue.sv =====
// Short FIFO of classified words between parser and message stage.
// Depends on wsdf_pkg (op_t, Q_DEPTH).
module wsdf_queue import wsdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wr_op,
  input  logic pop,
  output op_t  rd_op,
  output logic full,
  output logic not_empty
);

  op_t               slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign rd_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/wsdf_back.sv =====
// Message stage: close-code capture, end events and the output register.
// Depends on wsdf_pkg; takes words from wsdf_queue.
module wsdf_back import wsdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  op_t         q_op,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_byte,
  output logic [7:0]  payload_byte,
  output logic [2:0]  event_kind,
  output logic [15:0] close_code
);

  logic [1:0]  msg_cnt;
  logic [15:0] close_bytes;
  logic [1:0]  cnt_d;
  logic [15:0] close_d;
  logic        has_d;
  logic [2:0]  kind_d;
  logic [15:0] code_d;
  logic        produce;

  always_comb begin
    cnt_d   = msg_cnt;
    close_d = close_bytes;
    if (q_op.is_data) begin
      if (msg_cnt < 2'd2) close_d = {close_bytes[7:0], q_op.data};
      if (msg_cnt != 2'd3) cnt_d = msg_cnt + 2'd1;
    end
    has_d  = q_op.is_data && (q_op.mtype == EV_TEXT || q_op.mtype == EV_BINARY);
    kind_d = q_op.is_err ? EV_ERROR : (q_op.is_end ? q_op.mtype : EV_NONE);
    code_d = (q_op.is_end && q_op.mtype == EV_CLOSE && cnt_d == 2'd2) ? close_d : 16'd0;
    produce = has_d || (kind_d != EV_NONE);
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      msg_cnt     <= 2'd0;
      close_bytes <= 16'd0;
    end else begin
      if (q_pop) begin
        out_valid <= produce;
        if (q_op.is_end) begin
          msg_cnt     <= 2'd0;
          close_bytes <= 16'd0;
        end else begin
          msg_cnt     <= cnt_d;
          close_bytes <= close_d;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && produce) begin
      has_byte     <= has_d;
      payload_byte <= has_d ? q_op.data : 8'd0;
      event_kind   <= kind_d;
      close_code   <= code_d;
    end
  end

endmodule

// ===== src/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer, top level.
// Depends on wsdf_pkg, wsdf_front, wsdf_queue and wsdf_back.
//
// Input channel: one stream byte per word on stream_byte, valid/ready.
// Output channel: one result word (has_byte, payload_byte, event_kind,
// close_code), valid/ready. Header, length, mask key and control-frame
// payload bytes produce no word; text/binary payload bytes and end events
// of final frames do, and a protocol error produces one word, after which
// the parser ignores the stream until reset.
// Throughput: one byte per cycle while no output stall backs up the queue.
// The header parser handles every byte as it is accepted; the message
// stage pops one queued word per cycle while the output word is not stalled.
// The parser is combinational; a result word passes a queue slot, then
// the output register.
// Reset (synchronous, active high) returns the parser to the first header
// byte, empties the two-word queue and drops any pending result.
// When the receiver stalls, the output word holds; the queue absorbs two
// more words before in_ready falls.
module websocket_frame_deframer_core import wsdf_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_byte,
  output logic [7:0]  payload_byte,
  output logic [2:0]  event_kind,
  output logic [15:0] close_code
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  op_t  wr_op;
  op_t  rd_op;

  wsdf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .stream_byte(stream_byte),
    .q_full     (q_full),
    .push       (q_push),
    .op         (wr_op)
  );

  wsdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_op    (wr_op),
    .pop      (q_pop),
    .rd_op    (rd_op),
    .full     (q_full),
    .not_empty(q_valid)
  );

  wsdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (rd_op),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .has_byte    (has_byte),
    .payload_byte(payload_byte),
    .event_kind  (event_kind),
    .close_code  (close_code)
  );

endmodule

// ===== src/wsdf_port_chk.sv =====
// Port-level assertions for the deframer top level, bound in below.
// Depends on wsdf_pkg and websocket_frame_deframer_core.
module wsdf_port_chk import wsdf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        has_byte,
  input logic [7:0]  payload_byte,
  input logic [2:0]  event_kind,
  input logic [15:0] close_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(has_byte) && $stable(payload_byte)
      && $stable(event_kind) && $stable(close_code))
    else $error("output word changed while stalled");

  // no empty result words
  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> has_byte || event_kind != EV_NONE)
    else $error("empty result word");

  a_code_close_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_CLOSE |-> close_code == 16'd0)
    else $error("close code on non-close event");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> payload_byte == 8'd0)
    else $error("payload byte without has_byte");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word survived reset");

endmodule

bind websocket_frame_deframer_core wsdf_port_chk u_port_chk (.*);

// ===== dv/websocket_frame_deframer_core_tb.sv =====
// Self-checking testbench for websocket_frame_deframer_core.
// Depends on wsdf_pkg and the deframer RTL; frames are built here, the
// expected words come from a frame tracker kept in step with the stream.
module websocket_frame_deframer_core_tb import wsdf_pkg::*;;

  typedef struct {
    bit        has;
    bit [7:0]  data;
    bit [2:0]  kind;
    bit [15:0] code;
  } deframer_word_t;

  // how the payload length is carried in the header
  typedef enum int {FORM_7, FORM_16, FORM_64} len_form_t;

  class deframe_scoreboard;
    phase_t                   phase;
    bit                       fin;
    bit [2:0]                 msg_type;
    bit                       masked;
    bit [LENGTH_BITS_DEF-1:0] remaining;
    bit [3:0]                 len_left;
    bit [7:0]                 key[4];
    bit [1:0]                 key_pos;
    bit [1:0]                 msg_count;
    bit [15:0]                close_word;
    deframer_word_t           expected_words[$];
    int                       errors;

    function new();
      phase      = PH_HDR0;
      fin        = 1'b0;
      msg_type   = EV_NONE;
      masked     = 1'b0;
      remaining  = '0;
      len_left   = '0;
      key        = '{default: 8'h00};
      key_pos    = '0;
      msg_count  = '0;
      close_word = '0;
      errors     = 0;
    endfunction

    // frame complete; only a final frame closes the message
    function void finish_frame(output bit [2:0] kind, output bit [15:0] code);
      kind  = EV_NONE;
      code  = '0;
      phase = PH_HDR0;
      if (fin) begin
        kind = msg_type;
        if (kind == EV_CLOSE && msg_count == 2'd2) code = close_word;
        msg_type   = EV_NONE;
        msg_count  = '0;
        close_word = '0;
      end
    endfunction

    function void length_known(output bit [2:0] kind, output bit [15:0] code);
      kind = EV_NONE;
      code = '0;
      if (masked) begin
        phase   = PH_KEY;
        key_pos = '0;
      end else if (remaining == 0) begin
        finish_frame(kind, code);
      end else begin
        phase = PH_DATA;
      end
    endfunction

    function void note_stream_byte(bit [7:0] b);
      deframer_word_t w;
      bit [3:0]       op;
      bit [2:0]       t;
      bit             ok;
      bit [7:0]       d;
      w = '{has: 1'b0, data: 8'h00, kind: EV_NONE, code: 16'h0000};
      case (phase)
        PH_HDR0: begin
          op = b[3:0];
          t  = EV_NONE;
          ok = (b[6:4] == 3'b000);
          if (ok) begin
            if (op == OPC_CONT) ok = (msg_type != EV_NONE);
            else if (msg_type != EV_NONE) ok = 1'b0;
            else begin
              case (op)
                OPC_TEXT:   t = EV_TEXT;
                OPC_BINARY: t = EV_BINARY;
                OPC_CLOSE:  t = EV_CLOSE;
                OPC_PING:   t = EV_PING;
                OPC_PONG:   t = EV_PONG;
                default:    ok = 1'b0;
              endcase
            end
          end
          if (!ok) begin
            phase  = PH_ERR;
            w.kind = EV_ERROR;
          end else begin
            if (t != EV_NONE) msg_type = t;
            fin   = b[7];
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          masked    = b[7];
          remaining = '0;
          if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
            len_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase    = PH_EXT;
          end else begin
            len_left  = '0;
            remaining = LENGTH_BITS_DEF'(b[6:0]);
            length_known(w.kind, w.code);
          end
        end
        PH_EXT: begin
          remaining = (remaining << 8) | b;
          len_left  = len_left - 1'b1;
          if (len_left == 0) length_known(w.kind, w.code);
        end
        PH_KEY: begin
          key[key_pos] = b;
          key_pos      = key_pos + 1'b1;
          if (key_pos == 0) begin
            if (remaining == 0) finish_frame(w.kind, w.code);
            else phase = PH_DATA;
          end
        end
        PH_DATA: begin
          d = b;
          if (masked) begin
            d       = d ^ key[key_pos];
            key_pos = key_pos + 1'b1;
          end
          if (msg_count < 2'd2) close_word = {close_word[7:0], d};
          if (msg_count < 2'd3) msg_count = msg_count + 1'b1;
          if (msg_type == EV_TEXT || msg_type == EV_BINARY) begin
            w.has  = 1'b1;
            w.data = d;
          end
          remaining = remaining - 1'b1;
          if (remaining == 0) finish_frame(w.kind, w.code);
        end
        default: ;  // error phase: stream ignored until reset
      endcase
      if (w.has || w.kind != EV_NONE) expected_words.insert(expected_words.size(), w);
    endfunction

    function void check_result(deframer_word_t got);
      deframer_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: has_byte %0d payload_byte %02h event_kind %0d close_code %04h",
               got.has, got.data, got.kind, got.code);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.has != want.has) begin
        $error("has_byte: expected %0d, actual %0d", want.has, got.has);
        errors++;
      end
      if (got.data != want.data) begin
        $error("payload_byte: expected %02h, actual %02h", want.data, got.data);
        errors++;
      end
      if (got.kind != want.kind) begin
        $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.code != want.code) begin
        $error("close_code: expected %04h, actual %04h", want.code, got.code);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic        has_byte;
  logic [7:0]  payload_byte;
  logic [2:0]  event_kind;
  logic [15:0] close_code;

  deframe_scoreboard sb = new();
  bit no_gaps;     // sender skips its idle cycles
  bit hold_req;    // asks the receiver for a long hold-off
  int bytes_sent;

  websocket_frame_deframer_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .has_byte    (has_byte),
    .payload_byte(payload_byte),
    .event_kind  (event_kind),
    .close_code  (close_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("websocket_frame_deframer_core_tb: errors");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input bit [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    stream_byte = b;
    do @(posedge clk); while (!in_ready);
    sb.note_stream_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input bit fin, input logic [3:0] opc, input bit masked,
                            input int len, input len_form_t form);
    send_byte({fin, 3'b000, opc});
    case (form)
      FORM_7: send_byte({masked, 7'(len)});
      FORM_16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        repeat (6) send_byte(8'h00);
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end
    endcase
    if (masked) repeat (4) send_byte(8'($urandom));
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic send_message();
    logic [3:0] opc;
    int         frags;
    int         len;
    int         r;
    len_form_t  form;
    r = $urandom_range(0, 9);
    if (r < 4) opc = OPC_TEXT;
    else if (r < 7) opc = OPC_BINARY;
    else if (r == 7) opc = OPC_CLOSE;
    else if (r == 8) opc = OPC_PING;
    else opc = OPC_PONG;
    frags = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    for (int f = 0; f < frags; f++) begin
      // close payloads stay short so the two-byte code case comes up often
      if (opc == OPC_CLOSE) len = $urandom_range(0, 3);
      else begin
        r = $urandom_range(0, 39);
        if (r < 24) len = $urandom_range(0, 8);
        else if (r < 38) len = $urandom_range(9, 40);
        else len = $urandom_range(126, 160);
      end
      r = $urandom_range(0, 9);
      if (len > 125) form = (r < 5) ? FORM_16 : FORM_64;
      else if (r < 7) form = FORM_7;
      else if (r < 9) form = FORM_16;
      else form = FORM_64;
      send_frame(f == frags - 1, (f == 0) ? opc : OPC_CONT, 1'($urandom), len, form);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  // result side
  initial begin
    int             stall;
    bit             rx_fast;
    deframer_word_t got;
    out_ready = 1'b0;
    rx_fast   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (250) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 24) == 0) rx_fast = ~rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{has: has_byte, data: payload_byte, kind: event_kind, code: close_code};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // stream side
  initial begin
    logic [3:0] op;
    logic [3:0] starts[5];
    rst         = 1'b1;
    in_valid    = 1'b0;
    stream_byte = 8'h00;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    starts      = '{OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: empty text, masked binary, two-byte close, fragmented pong
    // with extended-length fragments (an empty one, then a one-byte one)
    send_frame(1'b1, OPC_TEXT, 1'b0, 0, FORM_7);
    send_frame(1'b1, OPC_BINARY, 1'b1, 2, FORM_7);
    send_frame(1'b1, OPC_CLOSE, 1'b0, 2, FORM_7);
    send_frame(1'b0, OPC_PONG, 1'b0, 0, FORM_16);
    send_frame(1'b1, OPC_CONT, 1'b0, 1, FORM_64);
    in_valid = 1'b0;
    wait_drained();

    // receiver backs off while the sender streams flat out
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    send_frame(1'b1, OPC_TEXT, 1'b1, 60, FORM_7);
    no_gaps  = 1'b0;
    in_valid = 1'b0;
    wait_drained();

    while (bytes_sent < 630) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      send_message();
    end
    no_gaps = 1'b0;

    // one protocol error is all a run can see: it is sticky until reset
    case ($urandom_range(0, 3))
      0: send_byte({1'($urandom), 3'($urandom_range(1, 7)), starts[$urandom_range(0, 4)]});
      1: begin
        do op = 4'($urandom);
        while (op inside {OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG});
        send_byte({1'($urandom), 3'b000, op});
      end
      2: send_byte({1'($urandom), 3'b000, OPC_CONT});
      default: begin
        send_frame(1'b0, starts[$urandom_range(0, 4)], 1'($urandom), 3, FORM_7);
        send_byte({1'($urandom), 3'b000, starts[$urandom_range(0, 4)]});
      end
    endcase
    repeat (12) send_byte(8'($urandom));
    in_valid = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("websocket_frame_deframer_core_tb: clean");
    end else begin
      $display("websocket_frame_deframer_core_tb: errors");
    end
    $finish;
  end

endmodule
